@@ sv/dtrg_pkg.sv @@
// Shared constants, types and functions of the double twister random generator.
package dtrg_pkg;

    // Store geometry
    localparam int STATE_WORDS = 191;
    localparam int LANE_COUNT  = 2 * STATE_WORDS;
    localparam int ADDR_W      = $clog2(STATE_WORDS);
    localparam int PTR_W       = $clog2(LANE_COUNT + 2);
    localparam int WORD_W      = 128;
    localparam int LANE_W      = 64;
    localparam int FRAC_W      = 52;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_LANE0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_LANE1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MANTISSA_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT_BITS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_INTERVAL = 3'd4;

    // Output interval codes
    localparam logic [1:0] INTV_ONE_TWO     = 2'd0;
    localparam logic [1:0] INTV_CLOSED_OPEN = 2'd1;
    localparam logic [1:0] INTV_OPEN_CLOSED = 2'd2;
    localparam logic [1:0] INTV_OPEN_OPEN   = 2'd3;

    // Register reset values
    localparam logic [63:0] RST_MANTISSA_MASK = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] RST_EXPONENT_BITS = 64'h3FF0_0000_0000_0000;

    // Seeding and tempering constants
    localparam logic [63:0] SEED_MULT   = 64'd6364136223846793005;
    localparam logic [63:0] TEMPER_M1   = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TEMPER_M2   = 64'h71D6_7FFF_EDA6_0000;
    localparam logic [63:0] TEMPER_M3   = 64'hFFF7_EEE0_0000_0000;
    localparam logic [52:0] FRAC_ONE    = 53'h10_0000_0000_0000;
    localparam logic [10:0] EXP_BIAS    = 11'd1023;

    // Request to and response from the normalizer
    typedef struct packed {
        logic        start;
        logic [52:0] num;
    } t_norm_req;

    typedef struct packed {
        logic        done;
        logic [63:0] value;
    } t_norm_rsp;

    // Output tempering of one lane
    function automatic logic [63:0] f_temper(input logic [63:0] a_in);
        logic [63:0] a;
        a = a_in;
        a = a ^ ((a >> 29) & TEMPER_M1);
        a = a ^ ((a << 17) & TEMPER_M2);
        a = a ^ ((a << 37) & TEMPER_M3);
        a = a ^ (a >> 43);
        return a;
    endfunction

    // New word from old word and lung
    function automatic logic [WORD_W-1:0] f_recur_word(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] lung,
        input logic [63:0]       m0,
        input logic [63:0]       m1
    );
        logic [63:0] w0;
        logic [63:0] w1;
        w0 = lung[127:64] ^ (a[63:0] >> 1) ^ (a[63:0] & m0);
        w1 = lung[63:0] ^ (a[127:64] >> 1) ^ (a[127:64] & m1);
        return {w1, w0};
    endfunction

    // New lung from old word and lung
    function automatic logic [WORD_W-1:0] f_recur_lung(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] lung
    );
        logic [63:0] l0;
        logic [63:0] l1;
        l0 = (lung[63:0] << 8) ^ lung[63:0] ^ a[63:0];
        l1 = (lung[127:64] << 8) ^ lung[127:64] ^ a[127:64];
        return {l1, l0};
    endfunction

endpackage

@@ sv/dtrg_in_if.sv @@
// Request channel: mode and seed with valid/ready.
interface dtrg_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] seed;

    modport source (output valid, output mode, output seed, input ready);
    modport sink   (input valid, input mode, input seed, output ready);
endinterface

@@ sv/dtrg_out_if.sv @@
// Result channel: double bit pattern with valid/ready.
interface dtrg_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

@@ sv/dtrg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dtrg_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 191
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/dtrg_norm.sv @@
// Iterative normalizer: turns n / 2^52 into an exact IEEE double.
module dtrg_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dtrg_pkg::t_norm_req i_req,
    output dtrg_pkg::t_norm_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [52:0] r_n;
    logic [5:0]  r_s;
    logic [63:0] r_value;

    // Control: busy until the leading one reaches bit 52
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.num == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_n[52]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: coarse then fine left shifts
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_n     <= i_req.num;
            r_s     <= '0;
            r_value <= '0;
        end else if (r_busy) begin
            priority if (r_n[52]) begin
                r_value <= {1'b0, dtrg_pkg::EXP_BIAS - {5'd0, r_s}, r_n[51:0]};
            end else if (r_n[52:37] == '0) begin
                r_n <= r_n << 16;
                r_s <= r_s + 6'd16;
            end else if (r_n[52:49] == '0) begin
                r_n <= r_n << 4;
                r_s <= r_s + 6'd4;
            end else begin
                r_n <= r_n << 1;
                r_s <= r_s + 6'd1;
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

endmodule

@@ sv/double_twister_random_generator.sv @@
// Double twister random generator: word store, sequencer and output stage.
//
// Requests arrive on i_draw (valid/ready). A request with mode 0 seeds the
// generator from its 64-bit seed and gives no result; a request with mode 1
// draws one number, returned as a 64-bit double pattern on o_result.
// Configuration registers must be written through i_cfg_we/i_cfg_idx/
// i_cfg_data while no request is in flight; the block does not enforce it.
// One request is worked on at a time; i_draw.ready is high only when the
// sequencer is idle. Seeding runs each lane through the shared 32x32
// multiplier, which builds each 64-bit product in three passes. A draw
// in the [1,2) interval skips the normalizer; the converted intervals
// wait while the shift normalizer iterates. Every 382nd draw first
// rewrites the whole store, one word per cycle through the RAM port.
// Results sit in an output register: a stalled receiver holds the result
// but the next request is still accepted and worked up to its end.
// Reset (synchronous, active low) restores register defaults and marks the
// store as used up; the store itself holds nothing until seeded.
module double_twister_random_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    dtrg_in_if.sink                           i_draw,
    dtrg_out_if.source                        o_result,
    input  logic                              i_cfg_we,
    input  logic [dtrg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [63:0]                       i_cfg_data
);

    localparam int AW = dtrg_pkg::ADDR_W;
    localparam int PW = dtrg_pkg::PTR_W;
    localparam int WW = dtrg_pkg::WORD_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEED   = 3'd1;
    localparam logic [2:0] S_REGEN  = 3'd2;
    localparam logic [2:0] S_ISSUE  = 3'd3;
    localparam logic [2:0] S_TEMPER = 3'd4;
    localparam logic [2:0] S_CONV   = 3'd5;
    localparam logic [2:0] S_NORM   = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    // Seed multiply passes
    localparam logic [1:0] PH_LO_LO = 2'd0;
    localparam logic [1:0] PH_HI_LO = 2'd1;
    localparam logic [1:0] PH_LO_HI = 2'd2;

    localparam logic [AW-1:0] LAST_WORD = AW'(dtrg_pkg::STATE_WORDS - 1);
    localparam logic [PW-1:0] PTR_END   = PW'(dtrg_pkg::LANE_COUNT);
    localparam logic [PW-1:0] SEED_LAST = PW'(dtrg_pkg::LANE_COUNT + 1);

    // Configuration
    logic [63:0] r_mask0;
    logic [63:0] r_mask1;
    logic [63:0] r_mmask;
    logic [63:0] r_exp;
    logic [1:0]  r_intv;

    // Sequencer and datapath state
    logic [2:0]    r_state;
    logic [PW-1:0] r_rptr;
    logic          r_lane;
    logic [WW-1:0] r_lung;
    logic [63:0]   r_prev;
    logic [63:0]   r_even;
    logic [63:0]   r_acc;
    logic [PW-1:0] r_idx;
    logic [1:0]    r_ph;
    logic [AW-1:0] r_cnt;
    logic          r_rd_on;
    logic          r_wv;
    logic [AW-1:0] r_wa;
    logic [63:0]   r_res;
    logic          r_out_valid;
    logic [63:0]   r_out_value;

    // RAM port controls
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [WW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [WW-1:0] w_rdata;

    // Seed multiplier and misc
    logic [63:0] w_x;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic [63:0] w_seed_val;
    logic [63:0] w_lane;
    logic [63:0] w_pat;
    logic [51:0] w_m;
    logic        w_accept;
    logic        w_out_load;

    dtrg_pkg::t_norm_req w_norm_req;
    dtrg_pkg::t_norm_rsp w_norm_rsp;

    assign w_accept   = i_draw.valid && i_draw.ready;
    assign w_out_load = (r_state == S_FINISH) && (!r_out_valid || o_result.ready);

    // Shared 32x32 multiplier for the seeding recurrence
    assign w_x        = r_prev ^ (r_prev >> 62);
    assign w_mul_a    = (r_ph == PH_HI_LO) ? w_x[63:32] : w_x[31:0];
    assign w_mul_b    = (r_ph == PH_LO_HI) ? dtrg_pkg::SEED_MULT[63:32]
                                           : dtrg_pkg::SEED_MULT[31:0];
    assign w_prod     = {32'd0, w_mul_a} * {32'd0, w_mul_b};
    assign w_seed_val = r_acc + {w_prod[31:0], 32'd0};

    // Drawn lane, tempered, masked and given the exponent bits ([1,2) by default)
    assign w_lane = r_lane ? w_rdata[127:64] : w_rdata[63:0];
    assign w_pat  = (dtrg_pkg::f_temper(w_lane) & r_mmask) | r_exp;
    assign w_m    = r_res[51:0];

    // RAM port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wa;
        w_wdata = dtrg_pkg::f_recur_word(w_rdata, r_lung, r_mask0, r_mask1);
        w_raddr = r_rptr[AW:1];
        if (r_state == S_REGEN) begin
            w_we    = r_wv;
            w_raddr = r_cnt;
        end else if (r_state == S_SEED) begin
            w_we    = (r_ph == PH_LO_HI) && r_idx[0] && (r_idx < PTR_END);
            w_waddr = r_idx[AW:1];
            w_wdata = {w_seed_val, r_even};
        end
    end

    // Normalizer request
    always_comb begin
        w_norm_req.start = (r_state == S_CONV);
        unique case (r_intv)
            dtrg_pkg::INTV_ONE_TWO:     w_norm_req.num = {1'b0, w_m};
            dtrg_pkg::INTV_CLOSED_OPEN: w_norm_req.num = {1'b0, w_m};
            dtrg_pkg::INTV_OPEN_CLOSED: w_norm_req.num = dtrg_pkg::FRAC_ONE - {1'b0, w_m};
            dtrg_pkg::INTV_OPEN_OPEN:   w_norm_req.num = {1'b0, w_m[51:1], 1'b1};
            default:                    w_norm_req.num = {1'b0, w_m};
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask0 <= '0;
            r_mask1 <= '0;
            r_mmask <= dtrg_pkg::RST_MANTISSA_MASK;
            r_exp   <= dtrg_pkg::RST_EXPONENT_BITS;
            r_intv  <= dtrg_pkg::INTV_ONE_TWO;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dtrg_pkg::CFG_MASK_LANE0:      r_mask0 <= i_cfg_data;
                dtrg_pkg::CFG_MASK_LANE1:      r_mask1 <= i_cfg_data;
                dtrg_pkg::CFG_MANTISSA_MASK:   r_mmask <= i_cfg_data;
                dtrg_pkg::CFG_EXPONENT_BITS:   r_exp   <= i_cfg_data;
                dtrg_pkg::CFG_OUTPUT_INTERVAL: r_intv  <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rptr  <= PTR_END;
            r_ph    <= PH_LO_LO;
            r_rd_on <= 1'b0;
            r_wv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!i_draw.mode) begin
                            r_ph    <= PH_LO_LO;
                            r_state <= S_SEED;
                        end else if (r_rptr >= PTR_END) begin
                            r_rd_on <= 1'b1;
                            r_wv    <= 1'b0;
                            r_state <= S_REGEN;
                        end else begin
                            // read issued from this cycle's pointer
                            r_rptr  <= r_rptr + PW'(1);
                            r_state <= S_TEMPER;
                        end
                    end
                end
                S_SEED: begin
                    unique case (r_ph)
                        PH_LO_LO: r_ph <= PH_HI_LO;
                        PH_HI_LO: r_ph <= PH_LO_HI;
                        default: begin
                            r_ph <= PH_LO_LO;
                            if (r_idx == SEED_LAST) begin
                                r_rptr  <= PTR_END;
                                r_state <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_REGEN: begin
                    r_wv <= r_rd_on;
                    if (r_rd_on && r_cnt == LAST_WORD) begin
                        r_rd_on <= 1'b0;
                    end
                    if (r_wv && r_wa == LAST_WORD) begin
                        r_rptr  <= '0;
                        r_wv    <= 1'b0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_rptr  <= r_rptr + PW'(1);
                    r_state <= S_TEMPER;
                end
                S_TEMPER: begin
                    r_state <= (r_intv == dtrg_pkg::INTV_ONE_TWO) ? S_FINISH : S_CONV;
                end
                S_CONV: begin
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (w_norm_rsp.done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // seeding: three multiply passes per lane
        if (r_state == S_IDLE && w_accept) begin
            r_prev <= i_draw.seed;
            r_even <= i_draw.seed;
            r_idx  <= PW'(1);
        end else if (r_state == S_SEED) begin
            unique case (r_ph)
                PH_LO_LO: r_acc <= w_prod + 64'(r_idx);
                PH_HI_LO: r_acc <= r_acc + {w_prod[31:0], 32'd0};
                default: begin
                    r_prev <= w_seed_val;
                    r_idx  <= r_idx + PW'(1);
                    if (!r_idx[0]) begin
                        r_even <= w_seed_val;
                    end else if (r_idx >= PTR_END) begin
                        r_lung <= {w_seed_val, r_even};
                    end
                end
            endcase
        end

        // regeneration: read word, write its new value back in the next cycle
        if (r_state == S_IDLE) begin
            r_cnt <= '0;
        end else if (r_state == S_REGEN) begin
            r_wa <= r_cnt;
            if (r_rd_on && r_cnt != LAST_WORD) begin
                r_cnt <= r_cnt + AW'(1);
            end
            if (r_wv) begin
                r_lung <= dtrg_pkg::f_recur_lung(w_rdata, r_lung);
            end
        end

        // lane select follows the read
        if ((r_state == S_IDLE) || (r_state == S_ISSUE)) begin
            r_lane <= r_rptr[0];
        end

        if (r_state == S_TEMPER) begin
            r_res <= w_pat;
        end else if (r_state == S_NORM && w_norm_rsp.done) begin
            r_res <= w_norm_rsp.value;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_value <= r_res;
        end
    end

    assign i_draw.ready   = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.value = r_out_value;

    dtrg_ram #(
        .WIDTH (WW),
        .DEPTH (dtrg_pkg::STATE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dtrg_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_norm_req),
        .o_rsp   (w_norm_rsp)
    );

endmodule

@@ tb/testbench.sv @@
// Testbench for the double twister random generator: seeded draws checked against a predictor.
`timescale 1ns / 100ps

module testbench;
    import dtrg_pkg::*;

    // Request modes
    localparam logic MODE_SEED = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    // Tempering masks and fraction field of a double
    localparam logic [63:0] TMP_MASK_A = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TMP_MASK_B = 64'h71D6_7FFF_EDA6_0000;
    localparam logic [63:0] TMP_MASK_C = 64'hFFF7_EEE0_0000_0000;
    localparam logic [63:0] FRAC_BITS  = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] MULT_LCG   = 64'd6364136223846793005;
    localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

    // Usual recursion masks of the 19937 variant
    localparam logic [63:0] STD_MASK_LO = 64'h000F_FAFF_FFFF_FB3F;
    localparam logic [63:0] STD_MASK_HI = 64'h000F_FDFF_FC90_FFFD;

    localparam int SETTLE_CYCLES  = 1400;
    localparam int TIMEOUT_CYCLES = 800000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 188;
    localparam int SEED_ODDS      = 250;
    localparam int PRINT_LIMIT    = 40;

    // Predicts the number stream and holds the values still owed by the block
    class rng_scoreboard;
        logic [127:0] words [STATE_WORDS];
        logic [127:0] lung;
        int unsigned  lane_ptr;
        logic [63:0]  mask_lo;
        logic [63:0]  mask_hi;
        logic [63:0]  mant_mask;
        logic [63:0]  exp_bits;
        logic [1:0]   interval;
        logic [63:0]  owed_values [$];
        int unsigned  errors;

        function new();
            foreach (words[w]) words[w] = '0;
            lung      = '0;
            lane_ptr  = LANE_COUNT;
            mask_lo   = '0;
            mask_hi   = '0;
            mant_mask = RST_MANTISSA_MASK;
            exp_bits  = RST_EXPONENT_BITS;
            interval  = INTV_ONE_TWO;
            errors    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                CFG_MASK_LANE0:      mask_lo   = data;
                CFG_MASK_LANE1:      mask_hi   = data;
                CFG_MANTISSA_MASK:   mant_mask = data;
                CFG_EXPONENT_BITS:   exp_bits  = data;
                CFG_OUTPUT_INTERVAL: interval  = data[1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_values.size();
        endfunction

        // Lanes past the store land in the lung
        function void write_lane(int unsigned idx, logic [63:0] v);
            if (idx < LANE_COUNT) begin
                words[idx >> 1][64 * (idx & 1) +: 64] = v;
            end else begin
                lung[64 * ((idx - LANE_COUNT) & 1) +: 64] = v;
            end
        endfunction

        function void fill_from_seed(logic [63:0] s);
            logic [63:0] x;
            int unsigned i;
            x = s;
            write_lane(0, x);
            for (i = 1; i < LANE_COUNT + 2; i++) begin
                x = MULT_LCG * (x ^ (x >> 62)) + 64'(i);
                write_lane(i, x);
            end
            lane_ptr = LANE_COUNT;
        endfunction

        // Rewrite every word in order, carrying the lung along
        function void twist_store();
            logic [63:0] a0, a1, l0, l1;
            int w;
            for (w = 0; w < STATE_WORDS; w++) begin
                a0 = words[w][63:0];
                a1 = words[w][127:64];
                l0 = lung[63:0];
                l1 = lung[127:64];
                words[w][63:0]   = l1 ^ (a0 >> 1) ^ (a0 & mask_lo);
                words[w][127:64] = l0 ^ (a1 >> 1) ^ (a1 & mask_hi);
                lung[63:0]       = (l0 << 8) ^ l0 ^ a0;
                lung[127:64]     = (l1 << 8) ^ l1 ^ a1;
            end
        endfunction

        function logic [63:0] temper_lane(logic [63:0] v);
            logic [63:0] t;
            t = v;
            t = t ^ ((t >> 29) & TMP_MASK_A);
            t = t ^ ((t << 17) & TMP_MASK_B);
            t = t ^ ((t << 37) & TMP_MASK_C);
            t = t ^ (t >> 43);
            return t;
        endfunction

        // Exact double of n / 2^52
        function logic [63:0] frac_to_double(logic [52:0] n);
            int k;
            if (n == '0) return '0;
            k = 52;
            while (n[k] == 1'b0) k--;
            return (64'(1023 + k - 52) << 52) | ((64'(n) << (52 - k)) & FRAC_BITS);
        endfunction

        function logic [63:0] next_value();
            logic [63:0] v;
            logic [51:0] m;
            if (lane_ptr >= LANE_COUNT) begin
                twist_store();
                lane_ptr = 0;
            end
            v = words[lane_ptr >> 1][64 * (lane_ptr & 1) +: 64];
            lane_ptr++;
            v = (temper_lane(v) & mant_mask) | exp_bits;
            m = v[51:0];
            case (interval)
                INTV_CLOSED_OPEN: v = frac_to_double({1'b0, m});
                INTV_OPEN_CLOSED: v = frac_to_double(FRAC_ONE - {1'b0, m});
                INTV_OPEN_OPEN:   v = frac_to_double({1'b0, m[51:1], 1'b1});
                default: ;
            endcase
            return v;
        endfunction

        function void note_request(logic mode, logic [63:0] seed);
            if (mode == MODE_SEED) begin
                fill_from_seed(seed);
            end else begin
                owed_values.push_back(next_value());
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("mismatch %0d at %0t: %s got %h want %h", errors, $time, what, got, want);
        endtask

        task check_result(logic [63:0] value);
            logic [63:0] want;
            if (owed_values.size() == 0) begin
                report("unexpected result", value, '0);
            end else begin
                want = owed_values.pop_front();
                if (value !== want) report("value", value, want);
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [63:0]          i_cfg_data;

    dtrg_in_if  draw_if ();
    dtrg_out_if result_if ();

    double_twister_random_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_draw     (draw_if),
        .o_result   (result_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    rng_scoreboard sb;
    bit            seeded;
    int unsigned   cycle_count;
    int            rx_style;
    int            rx_left;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("FAIL double_twister_random_generator");
            $finish;
        end
    end

    // Receiver stalls: one of four ready styles, chosen anew when its countdown ends
    initial begin
        rx_style = 0;
        rx_left  = 0;
    end
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = $urandom_range(0, 3);
            rx_left  = $urandom_range(20, 300);
        end else begin
            rx_left--;
        end
        case (rx_style)
            0: result_if.ready <= 1'b1;
            1: result_if.ready <= ($urandom_range(0, 2) != 0);
            2: result_if.ready <= ((cycle_count % 13) >= 6);
            default: result_if.ready <= ((cycle_count % 64) > 40);
        endcase
    end

    // Accepted results are checked before a request of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) sb.check_result(result_if.value);
            if (draw_if.valid && draw_if.ready) sb.note_request(draw_if.mode, draw_if.seed);
        end
    end

    // One request; returns at the edge where it is taken
    task automatic send_request(input logic mode, input logic [63:0] seed);
        draw_if.valid <= 1'b1;
        draw_if.mode  <= mode;
        draw_if.seed  <= seed;
        @(posedge i_clk);
        while (!draw_if.ready) @(posedge i_clk);
        if (mode == MODE_SEED) seeded = 1'b1;
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            draw_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Always waits on the clock before it checks for owed results
    task automatic wait_for_results();
        draw_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // A seed gives no result, so allow its fill to finish before touching registers
    task automatic settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [63:0] m0, input logic [63:0] m1,
                              input logic [63:0] mm, input logic [63:0] eb,
                              input logic [1:0] iv);
        logic [CFG_IDX_W-1:0] regs [5];
        logic [63:0]          vals [5];
        int                   r;
        regs = '{CFG_MASK_LANE0, CFG_MASK_LANE1, CFG_MANTISSA_MASK,
                 CFG_EXPONENT_BITS, CFG_OUTPUT_INTERVAL};
        vals = '{m0, m1, mm, eb, {62'd0, iv}};
        for (r = 0; r < 5; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[r];
            i_cfg_data <= vals[r];
            sb.set_register(regs[r], vals[r]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly draws in bursts; a rare reseed; one full drain halfway
    task automatic random_phase(input int n_items);
        int sent;
        int burst;
        int k;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < n_items; k++) begin
                if (!seeded || $urandom_range(1, SEED_ODDS) == 1)
                    send_request(MODE_SEED, {$urandom, $urandom});
                else
                    send_request(MODE_DRAW, {$urandom, $urandom});
                sent++;
                if (sent == n_items / 2) wait_for_results();
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
        end
    endtask

    // Stimulus
    initial begin
        int p;
        logic [63:0] m0, m1, mm, eb;
        logic [1:0]  iv;

        sb                = new();
        seeded            = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_MASK_LANE0;
        i_cfg_data        = '0;
        draw_if.valid     = 1'b0;
        draw_if.mode      = MODE_SEED;
        draw_if.seed      = '0;
        result_if.ready   = 1'b1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme seeds at register defaults
        send_request(MODE_SEED, '0);
        send_request(MODE_DRAW, '0);
        send_request(MODE_DRAW, ALL_ONES);
        send_request(MODE_DRAW, '0);
        send_request(MODE_SEED, ALL_ONES);
        send_request(MODE_DRAW, ALL_ONES);
        send_request(MODE_DRAW, '0);
        send_request(MODE_DRAW, ALL_ONES);

        // Empty mantissa: interval ends 0, 1.0 and the smallest open value
        settle();
        set_config('0, '0, '0, '0, INTV_CLOSED_OPEN);
        send_request(MODE_DRAW, '0);
        settle();
        set_config('0, '0, '0, '0, INTV_OPEN_CLOSED);
        send_request(MODE_DRAW, '0);
        settle();
        set_config('0, '0, '0, '0, INTV_OPEN_OPEN);
        send_request(MODE_DRAW, '0);

        // Full masks: upper bits must not leak into converted values
        settle();
        set_config(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, INTV_ONE_TWO);
        send_request(MODE_DRAW, ALL_ONES);
        send_request(MODE_DRAW, '0);
        for (p = 1; p < 4; p++) begin
            settle();
            set_config(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 2'(p));
            send_request(MODE_DRAW, ALL_ONES);
        end

        // Random phases over several register settings
        for (p = 0; p < RANDOM_PHASES; p++) begin
            m0 = {$urandom, $urandom};
            m1 = {$urandom, $urandom};
            mm = {$urandom, $urandom};
            eb = {$urandom, $urandom};
            iv = 2'($urandom_range(0, 3));
            case (p)
                0: begin
                    m0 = STD_MASK_LO; m1 = STD_MASK_HI;
                    mm = RST_MANTISSA_MASK; eb = RST_EXPONENT_BITS; iv = INTV_ONE_TWO;
                end
                1: begin
                    m0 = STD_MASK_LO; m1 = STD_MASK_HI;
                    mm = RST_MANTISSA_MASK; eb = RST_EXPONENT_BITS; iv = INTV_CLOSED_OPEN;
                end
                2: begin
                    m0 = STD_MASK_LO; m1 = STD_MASK_HI;
                    mm = RST_MANTISSA_MASK; eb = RST_EXPONENT_BITS; iv = INTV_OPEN_CLOSED;
                end
                3: begin
                    m0 = STD_MASK_LO; m1 = STD_MASK_HI;
                    mm = RST_MANTISSA_MASK; eb = RST_EXPONENT_BITS; iv = INTV_OPEN_OPEN;
                end
                4: begin
                    m0 = ALL_ONES; m1 = ALL_ONES; mm = ALL_ONES; eb = ALL_ONES;
                end
                5: begin
                    m0 = '0; m1 = '0; mm = '0; eb = '0;
                end
                default: ;
            endcase
            settle();
            set_config(m0, m1, mm, eb, iv);
            random_phase(PHASE_ITEMS);
        end

        // Drain, then give stray results a chance to show up
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) sb.report("missing result", '0, sb.owed_values[0]);
        if (sb.errors == 0)
            $display("PASS double_twister_random_generator");
        else
            $display("FAIL double_twister_random_generator");
        $finish;
    end

endmodule
